// ----- hw/rtl/rsp_pkg.sv -----
`default_nettype none
package rsp_pkg;

  typedef struct packed {
    logic signed [31:0] numerator;
    logic signed [31:0] denominator;
    logic               first;
  } in_t;

  typedef struct packed {
    logic signed [63:0] max_num;
    logic        [62:0] max_den;
    logic signed [63:0] sum_num;
    logic        [62:0] sum_den;
    logic signed [63:0] prod_num;
    logic        [62:0] prod_den;
    logic               overflow;
    logic               bad_item;
  } out_t;

  // sequencer steps, also used as the command code to the datapath
  typedef enum logic [5:0] {
    ST_IDLE, ST_LOAD, ST_IG, ST_IDN, ST_IDD, ST_MM1, ST_MM2, ST_MDEC,
    ST_PG1, ST_PG2, ST_PD1, ST_PD2, ST_PD3, ST_PD4, ST_PM1, ST_PM2,
    ST_AG, ST_AD1, ST_AD2, ST_AM1, ST_AM2, ST_AADD, ST_AR, ST_AG2,
    ST_AQ, ST_AD3, ST_AM3, ST_SPREP, ST_SG, ST_SDN, ST_SDD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    TGT_MAX, TGT_PROD, TGT_SUM
  } tgt_t;

  typedef struct packed {
    state_t step;
    logic   accept;
    logic   start;
    logic   wb;
    tgt_t   tgt;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic bad;
    logic take_max;
    logic sum_zero;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ----- hw/rtl/rsp_div.sv -----
`default_nettype none
module rsp_div (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic         wide,
  input  wire logic [127:0] dividend,
  input  wire logic [63:0]  divisor,
  output logic              done,
  output logic [127:0]      quot,
  output logic [63:0]       rem
);

  logic [127:0] n_r, n_nxt;
  logic [63:0]  r_r, r_nxt;
  logic [63:0]  d_r, d_nxt;
  logic [6:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic         done_r, done_nxt;
  logic [63:0]  r_sh;
  logic         take;

  always_comb begin
    r_sh     = {r_r[62:0], n_r[127]};
    take     = r_r[63] || (r_sh >= d_r);
    n_nxt    = n_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      // narrow dividends start at the top so the quotient lands in the low half
      n_nxt    = wide ? dividend : {dividend[63:0], 64'd0};
      r_nxt    = 64'd0;
      d_nxt    = divisor;
      cnt_nxt  = wide ? 7'd127 : 7'd63;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      r_nxt = take ? (r_sh - d_r) : r_sh;
      n_nxt = {n_r[126:0], take};
      if (cnt_r == 7'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    r_r   <= r_nxt;
    d_r   <= d_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = n_r;
  assign rem  = r_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rsp_gcd.sv -----
`default_nettype none
module rsp_gcd (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      g
);

  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [5:0]  k_r, k_nxt;
  logic        busy_r, busy_nxt;

  assign done = busy_r && (a_r == 64'd0 || b_r == 64'd0);
  assign g    = ((a_r == 64'd0) ? b_r : a_r) << k_r;

  // binary gcd, one step a cycle
  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    k_nxt    = k_r;
    busy_nxt = busy_r;
    if (start) begin
      a_nxt    = a;
      b_nxt    = b;
      k_nxt    = 6'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (done) begin
        busy_nxt = 1'b0;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt = a_r >> 1;
        b_nxt = b_r >> 1;
        k_nxt = k_r + 6'd1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = a_r - b_r;
      end else begin
        b_nxt = b_r - a_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    k_r <= k_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rsp_ctrl.sv -----
`default_nettype none
module rsp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire rsp_pkg::sts_t sts,
  output rsp_pkg::cmd_t      cmd,
  output logic               in_stall
);

  rsp_pkg::state_t state_r, state_nxt;
  rsp_pkg::tgt_t   tgt_r, tgt_nxt;
  logic            issued_r, issued_nxt;
  logic            is_unit;

  always_comb begin
    case (state_r)
      rsp_pkg::ST_IDLE, rsp_pkg::ST_LOAD, rsp_pkg::ST_MDEC, rsp_pkg::ST_AADD,
      rsp_pkg::ST_SPREP, rsp_pkg::ST_OUT: is_unit = 1'b0;
      default:                            is_unit = 1'b1;
    endcase
  end

  // outputs
  always_comb begin
    cmd.step   = state_r;
    cmd.tgt    = tgt_r;
    cmd.accept = (state_r == rsp_pkg::ST_IDLE) && in_valid;
    cmd.start  = is_unit && !issued_r;
    case (state_r)
      rsp_pkg::ST_IDLE: cmd.wb = 1'b0;
      rsp_pkg::ST_OUT:  cmd.wb = sts.out_free;
      default:          cmd.wb = is_unit ? (issued_r && sts.done) : 1'b1;
    endcase
    in_stall = (state_r != rsp_pkg::ST_IDLE);
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    tgt_nxt    = tgt_r;
    issued_nxt = issued_r;
    if (cmd.start) begin
      issued_nxt = 1'b1;
    end else if (cmd.wb) begin
      issued_nxt = 1'b0;
    end
    case (state_r)
      rsp_pkg::ST_IDLE: if (in_valid) state_nxt = rsp_pkg::ST_LOAD;
      rsp_pkg::ST_LOAD: state_nxt = sts.bad ? rsp_pkg::ST_OUT : rsp_pkg::ST_IG;
      rsp_pkg::ST_MDEC: begin
        if (sts.take_max) begin
          state_nxt = rsp_pkg::ST_SPREP;
          tgt_nxt   = rsp_pkg::TGT_MAX;
        end else begin
          state_nxt = rsp_pkg::ST_PG1;
        end
      end
      rsp_pkg::ST_AADD: begin
        if (sts.sum_zero) begin
          state_nxt = rsp_pkg::ST_SPREP;
          tgt_nxt   = rsp_pkg::TGT_SUM;
        end else begin
          state_nxt = rsp_pkg::ST_AR;
        end
      end
      rsp_pkg::ST_SPREP: state_nxt = rsp_pkg::ST_SG;
      rsp_pkg::ST_OUT:   if (cmd.wb) state_nxt = rsp_pkg::ST_IDLE;
      default: begin
        if (cmd.wb) begin
          case (state_r)
            rsp_pkg::ST_IG:  state_nxt = rsp_pkg::ST_IDN;
            rsp_pkg::ST_IDN: state_nxt = rsp_pkg::ST_IDD;
            rsp_pkg::ST_IDD: state_nxt = rsp_pkg::ST_MM1;
            rsp_pkg::ST_MM1: state_nxt = rsp_pkg::ST_MM2;
            rsp_pkg::ST_MM2: state_nxt = rsp_pkg::ST_MDEC;
            rsp_pkg::ST_PG1: state_nxt = rsp_pkg::ST_PG2;
            rsp_pkg::ST_PG2: state_nxt = rsp_pkg::ST_PD1;
            rsp_pkg::ST_PD1: state_nxt = rsp_pkg::ST_PD2;
            rsp_pkg::ST_PD2: state_nxt = rsp_pkg::ST_PD3;
            rsp_pkg::ST_PD3: state_nxt = rsp_pkg::ST_PD4;
            rsp_pkg::ST_PD4: state_nxt = rsp_pkg::ST_PM1;
            rsp_pkg::ST_PM1: state_nxt = rsp_pkg::ST_PM2;
            rsp_pkg::ST_PM2: begin
              state_nxt = rsp_pkg::ST_SPREP;
              tgt_nxt   = rsp_pkg::TGT_PROD;
            end
            rsp_pkg::ST_AG:  state_nxt = rsp_pkg::ST_AD1;
            rsp_pkg::ST_AD1: state_nxt = rsp_pkg::ST_AD2;
            rsp_pkg::ST_AD2: state_nxt = rsp_pkg::ST_AM1;
            rsp_pkg::ST_AM1: state_nxt = rsp_pkg::ST_AM2;
            rsp_pkg::ST_AM2: state_nxt = rsp_pkg::ST_AADD;
            rsp_pkg::ST_AR:  state_nxt = rsp_pkg::ST_AG2;
            rsp_pkg::ST_AG2: state_nxt = rsp_pkg::ST_AQ;
            rsp_pkg::ST_AQ:  state_nxt = rsp_pkg::ST_AD3;
            rsp_pkg::ST_AD3: state_nxt = rsp_pkg::ST_AM3;
            rsp_pkg::ST_AM3: begin
              state_nxt = rsp_pkg::ST_SPREP;
              tgt_nxt   = rsp_pkg::TGT_SUM;
            end
            rsp_pkg::ST_SG:  state_nxt = rsp_pkg::ST_SDN;
            rsp_pkg::ST_SDN: state_nxt = rsp_pkg::ST_SDD;
            rsp_pkg::ST_SDD: begin
              case (tgt_r)
                rsp_pkg::TGT_MAX:  state_nxt = rsp_pkg::ST_PG1;
                rsp_pkg::TGT_PROD: state_nxt = rsp_pkg::ST_AG;
                default:           state_nxt = rsp_pkg::ST_OUT;
              endcase
            end
            default: state_nxt = rsp_pkg::ST_IDLE;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rsp_pkg::ST_IDLE;
      tgt_r    <= rsp_pkg::TGT_MAX;
      issued_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      tgt_r    <= tgt_nxt;
      issued_r <= issued_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/rsp_dpath.sv -----
`default_nettype none
module rsp_dpath #(
  parameter int INPUT_WIDTH = 32,
  parameter int ACC_WIDTH   = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire rsp_pkg::cmd_t cmd,
  input  wire rsp_pkg::in_t  in_data,
  input  wire logic          out_stall,
  output rsp_pkg::sts_t      sts,
  output logic               out_valid,
  output rsp_pkg::out_t      out_data
);

  localparam logic [63:0] ACC_MASK = {64{1'b1}} >> (64 - ACC_WIDTH);
  localparam logic [63:0] ACC_HALF = 64'd1 << (ACC_WIDTH - 1);

  rsp_pkg::in_t  in_r, in_nxt;
  rsp_pkg::out_t out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic [63:0]  sm_r, sm_nxt, sd_r, sd_nxt, g_r, g_nxt, g2_r, g2_nxt;
  logic [63:0]  t1_r, t1_nxt, t2_r, t2_nxt, t3_r, t3_nxt, t4_r, t4_nxt;
  logic [63:0]  i_mag_r, i_mag_nxt, i_den_r, i_den_nxt;
  logic         i_neg_r, i_neg_nxt, s_neg_r, s_neg_nxt, sv_neg_r, sv_neg_nxt;
  logic [127:0] l_r, l_nxt, r_r, r_nxt, s_nm_r, s_nm_nxt, s_dm_r, s_dm_nxt;
  logic         bad_r, bad_nxt, ovf_r, ovf_nxt, have_max_r, have_max_nxt;
  logic [63:0]  max_num_r, max_num_nxt, max_den_r, max_den_nxt;
  logic [63:0]  sum_num_r, sum_num_nxt, sum_den_r, sum_den_nxt;
  logic [63:0]  prod_num_r, prod_num_nxt, prod_den_r, prod_den_nxt;

  // shared multiplier: four 32x32 partial products, accumulated one after another
  logic [63:0]  ma_r, ma_nxt, mb_r, mb_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   mcnt_r, mcnt_nxt;
  logic         mbusy_r, mbusy_nxt, mdone_r, mdone_nxt;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;

  logic         use_div, use_gcd, use_mul, div_wide;
  logic [127:0] div_dvd, div_q;
  logic [63:0]  div_dvs, div_rem, gcd_a, gcd_b, gcd_g, mul_a, mul_b;
  logic         div_done, gcd_done;

  logic [63:0]  n_ext, d_ext, max_mag, p_mag, a_mag;
  logic         max_neg, p_neg, a_neg, bad_c;
  logic         ln, rn, gt;
  logic         add_neg;
  logic [127:0] add_m;
  logic         fits;
  logic [63:0]  v0, v, dcut;

  rsp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.start && use_div),
    .wide     (div_wide),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  rsp_gcd u_gcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && use_gcd),
    .a     (gcd_a),
    .b     (gcd_b),
    .done  (gcd_done),
    .g     (gcd_g)
  );

  always_comb begin
    pa = mcnt_r[1] ? ma_r[63:32] : ma_r[31:0];
    pb = mcnt_r[0] ? mb_r[63:32] : mb_r[31:0];
    pp = pa * pb;
    case (mcnt_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    acc_nxt   = acc_r;
    mcnt_nxt  = mcnt_r;
    mbusy_nxt = mbusy_r;
    mdone_nxt = 1'b0;
    if (cmd.start && use_mul) begin
      ma_nxt    = mul_a;
      mb_nxt    = mul_b;
      acc_nxt   = 128'd0;
      mcnt_nxt  = 2'd0;
      mbusy_nxt = 1'b1;
    end else if (mbusy_r) begin
      acc_nxt  = acc_r + pp_sh;
      mcnt_nxt = mcnt_r + 2'd1;
      if (mcnt_r == 2'd3) begin
        mbusy_nxt = 1'b0;
        mdone_nxt = 1'b1;
      end
    end
  end

  // item and accumulator views
  always_comb begin
    n_ext   = {{(64 - INPUT_WIDTH){in_r.numerator[INPUT_WIDTH-1]}},
               in_r.numerator[INPUT_WIDTH-1:0]};
    d_ext   = {{(64 - INPUT_WIDTH){in_r.denominator[INPUT_WIDTH-1]}},
               in_r.denominator[INPUT_WIDTH-1:0]};
    bad_c   = (in_r.denominator[INPUT_WIDTH-1:0] == '0);
    max_neg = max_num_r[63];
    max_mag = max_neg ? (64'd0 - max_num_r) : max_num_r;
    p_neg   = prod_num_r[63];
    p_mag   = p_neg ? (64'd0 - prod_num_r) : prod_num_r;
    a_neg   = sum_num_r[63];
    a_mag   = a_neg ? (64'd0 - sum_num_r) : sum_num_r;

    // exact compare of item against the stored maximum
    ln = i_neg_r && (l_r != 128'd0);
    rn = max_neg && (r_r != 128'd0);
    if (ln != rn) begin
      gt = !ln;
    end else begin
      gt = ln ? (l_r < r_r) : (l_r > r_r);
    end

    // signed-magnitude add of the two scaled numerators
    if (a_neg == i_neg_r) begin
      add_neg = a_neg;
      add_m   = l_r + r_r;
    end else if (l_r >= r_r) begin
      add_neg = a_neg;
      add_m   = l_r - r_r;
    end else begin
      add_neg = i_neg_r;
      add_m   = r_r - l_r;
    end
    if (add_m == 128'd0) add_neg = 1'b0;

    // wrap to accumulator width
    fits = (s_nm_r[127:64] == 64'd0)
        && ((s_nm_r[63:0] < ACC_HALF) || (s_neg_r && s_nm_r[63:0] == ACC_HALF))
        && (s_dm_r[127:64] == 64'd0) && (s_dm_r[63:0] < ACC_HALF)
        && (s_dm_r[63:0] != 64'd0);
    v0   = (s_neg_r ? (64'd0 - s_nm_r[63:0]) : s_nm_r[63:0]) & ACC_MASK;
    v    = ((v0 & ACC_HALF) != 64'd0) ? (v0 | ~ACC_MASK) : v0;
    dcut = s_dm_r[63:0] & (ACC_HALF - 64'd1);
    if (dcut == 64'd0) dcut = 64'd1;
  end

  // unit operand selection
  always_comb begin
    use_div  = 1'b0;
    use_gcd  = 1'b0;
    use_mul  = 1'b0;
    div_wide = 1'b0;
    div_dvd  = {64'd0, sm_r};
    div_dvs  = g_r;
    gcd_a    = sm_r;
    gcd_b    = sd_r;
    mul_a    = i_mag_r;
    mul_b    = max_den_r;
    case (cmd.step)
      rsp_pkg::ST_IG, rsp_pkg::ST_SG: use_gcd = 1'b1;
      rsp_pkg::ST_PG1: begin use_gcd = 1'b1; gcd_a = p_mag;   gcd_b = i_den_r;    end
      rsp_pkg::ST_PG2: begin use_gcd = 1'b1; gcd_a = i_mag_r; gcd_b = prod_den_r; end
      rsp_pkg::ST_AG:  begin use_gcd = 1'b1; gcd_a = sum_den_r; gcd_b = i_den_r;  end
      rsp_pkg::ST_AG2: begin use_gcd = 1'b1; gcd_a = t3_r;    gcd_b = g_r;        end
      rsp_pkg::ST_IDN, rsp_pkg::ST_SDN: use_div = 1'b1;
      rsp_pkg::ST_IDD, rsp_pkg::ST_SDD: begin use_div = 1'b1; div_dvd = {64'd0, sd_r}; end
      rsp_pkg::ST_PD1: begin use_div = 1'b1; div_dvd = {64'd0, p_mag}; end
      rsp_pkg::ST_PD2: begin
        use_div = 1'b1; div_dvd = {64'd0, i_mag_r}; div_dvs = g2_r;
      end
      rsp_pkg::ST_PD3: begin
        use_div = 1'b1; div_dvd = {64'd0, prod_den_r}; div_dvs = g2_r;
      end
      rsp_pkg::ST_PD4, rsp_pkg::ST_AD1: begin use_div = 1'b1; div_dvd = {64'd0, i_den_r}; end
      rsp_pkg::ST_AD2: begin use_div = 1'b1; div_dvd = {64'd0, sum_den_r}; end
      rsp_pkg::ST_AR:  begin use_div = 1'b1; div_wide = 1'b1; div_dvd = s_nm_r; end
      rsp_pkg::ST_AQ:  begin
        use_div = 1'b1; div_wide = 1'b1; div_dvd = s_nm_r; div_dvs = g2_r;
      end
      rsp_pkg::ST_AD3: begin
        use_div = 1'b1; div_dvd = {64'd0, i_den_r}; div_dvs = g2_r;
      end
      rsp_pkg::ST_MM1: use_mul = 1'b1;
      rsp_pkg::ST_MM2: begin use_mul = 1'b1; mul_a = max_mag; mul_b = i_den_r; end
      rsp_pkg::ST_PM1: begin use_mul = 1'b1; mul_a = t1_r;    mul_b = t2_r;    end
      rsp_pkg::ST_PM2: begin use_mul = 1'b1; mul_a = t3_r;    mul_b = t4_r;    end
      rsp_pkg::ST_AM1: begin use_mul = 1'b1; mul_a = a_mag;   mul_b = t1_r;    end
      rsp_pkg::ST_AM2: begin use_mul = 1'b1; mul_a = i_mag_r; mul_b = t2_r;    end
      rsp_pkg::ST_AM3: begin use_mul = 1'b1; mul_a = t2_r;    mul_b = t1_r;    end
      default: ;
    endcase
  end

  assign sts.done     = div_done || gcd_done || mdone_r;
  assign sts.bad      = bad_c;
  assign sts.take_max = !have_max_r || gt;
  assign sts.sum_zero = (add_m == 128'd0);
  assign sts.out_free = !out_valid_r || !out_stall;

  // writeback
  always_comb begin
    in_nxt = in_r;       out_nxt = out_r;
    sm_nxt = sm_r;       sd_nxt = sd_r;     g_nxt = g_r;       g2_nxt = g2_r;
    t1_nxt = t1_r;       t2_nxt = t2_r;     t3_nxt = t3_r;     t4_nxt = t4_r;
    i_mag_nxt = i_mag_r; i_den_nxt = i_den_r; i_neg_nxt = i_neg_r;
    s_neg_nxt = s_neg_r; sv_neg_nxt = sv_neg_r;
    l_nxt = l_r;         r_nxt = r_r;       s_nm_nxt = s_nm_r; s_dm_nxt = s_dm_r;
    bad_nxt = bad_r;     ovf_nxt = ovf_r;   have_max_nxt = have_max_r;
    max_num_nxt = max_num_r;   max_den_nxt = max_den_r;
    sum_num_nxt = sum_num_r;   sum_den_nxt = sum_den_r;
    prod_num_nxt = prod_num_r; prod_den_nxt = prod_den_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (cmd.accept) in_nxt = in_data;

    if (cmd.wb) begin
      case (cmd.step)
        rsp_pkg::ST_LOAD: begin
          sm_nxt    = n_ext[63] ? (64'd0 - n_ext) : n_ext;
          sd_nxt    = d_ext[63] ? (64'd0 - d_ext) : d_ext;
          i_neg_nxt = n_ext[63] ^ d_ext[63];
          bad_nxt   = bad_c;
          if (in_r.first && !bad_c) begin
            sum_num_nxt  = 64'd0;
            sum_den_nxt  = 64'd1;
            prod_num_nxt = 64'd1;
            prod_den_nxt = 64'd1;
            ovf_nxt      = 1'b0;
            have_max_nxt = 1'b0;
          end
        end
        rsp_pkg::ST_IG, rsp_pkg::ST_PG1, rsp_pkg::ST_AG, rsp_pkg::ST_SG: g_nxt = gcd_g;
        rsp_pkg::ST_PG2, rsp_pkg::ST_AG2: g2_nxt = gcd_g;
        rsp_pkg::ST_IDN: i_mag_nxt = div_q[63:0];
        rsp_pkg::ST_IDD: begin
          i_den_nxt = div_q[63:0];
          i_neg_nxt = i_neg_r && (i_mag_r != 64'd0);
        end
        rsp_pkg::ST_MM1, rsp_pkg::ST_AM1: l_nxt = acc_r;
        rsp_pkg::ST_MM2, rsp_pkg::ST_AM2: r_nxt = acc_r;
        rsp_pkg::ST_MDEC: begin
          have_max_nxt = 1'b1;
          s_neg_nxt    = i_neg_r;
          s_nm_nxt     = {64'd0, i_mag_r};
          s_dm_nxt     = {64'd0, i_den_r};
        end
        rsp_pkg::ST_PD1, rsp_pkg::ST_AD1, rsp_pkg::ST_AD3: t1_nxt = div_q[63:0];
        rsp_pkg::ST_PD2, rsp_pkg::ST_AD2: t2_nxt = div_q[63:0];
        rsp_pkg::ST_PD3: t3_nxt = div_q[63:0];
        rsp_pkg::ST_PD4: t4_nxt = div_q[63:0];
        rsp_pkg::ST_PM1: s_nm_nxt = acc_r;
        rsp_pkg::ST_PM2: begin
          // a zero product is held as a positive 0/1
          if (s_nm_r == 128'd0) begin
            s_neg_nxt = 1'b0;
            s_dm_nxt  = 128'd1;
          end else begin
            s_neg_nxt = p_neg ^ i_neg_r;
            s_dm_nxt  = acc_r;
          end
        end
        rsp_pkg::ST_AADD: begin
          s_neg_nxt = add_neg;
          s_nm_nxt  = add_m;
          s_dm_nxt  = 128'd1;
        end
        rsp_pkg::ST_AR:  t3_nxt = div_rem;
        rsp_pkg::ST_AQ:  s_nm_nxt = div_q;
        rsp_pkg::ST_AM3: s_dm_nxt = acc_r;
        rsp_pkg::ST_SPREP: begin
          if (!fits) ovf_nxt = 1'b1;
          sv_neg_nxt = v[63];
          sm_nxt     = v[63] ? (64'd0 - v) : v;
          sd_nxt     = dcut;
        end
        rsp_pkg::ST_SDN: sm_nxt = div_q[63:0];
        rsp_pkg::ST_SDD: begin
          case (cmd.tgt)
            rsp_pkg::TGT_MAX: begin
              max_num_nxt = sv_neg_r ? (64'd0 - sm_r) : sm_r;
              max_den_nxt = div_q[63:0];
            end
            rsp_pkg::TGT_PROD: begin
              prod_num_nxt = sv_neg_r ? (64'd0 - sm_r) : sm_r;
              prod_den_nxt = div_q[63:0];
            end
            default: begin
              sum_num_nxt = sv_neg_r ? (64'd0 - sm_r) : sm_r;
              sum_den_nxt = div_q[63:0];
            end
          endcase
        end
        rsp_pkg::ST_OUT: begin
          out_nxt.max_num  = max_num_r;
          out_nxt.max_den  = max_den_r[62:0];
          out_nxt.sum_num  = sum_num_r;
          out_nxt.sum_den  = sum_den_r[62:0];
          out_nxt.prod_num = prod_num_r;
          out_nxt.prod_den = prod_den_r[62:0];
          out_nxt.overflow = ovf_r;
          out_nxt.bad_item = bad_r;
          out_valid_nxt    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_nxt;    out_r <= out_nxt;
    sm_r <= sm_nxt;    sd_r <= sd_nxt;    g_r <= g_nxt;     g2_r <= g2_nxt;
    t1_r <= t1_nxt;    t2_r <= t2_nxt;    t3_r <= t3_nxt;   t4_r <= t4_nxt;
    i_mag_r <= i_mag_nxt; i_den_r <= i_den_nxt; i_neg_r <= i_neg_nxt;
    s_neg_r <= s_neg_nxt; sv_neg_r <= sv_neg_nxt;
    l_r <= l_nxt;      r_r <= r_nxt;      s_nm_r <= s_nm_nxt; s_dm_r <= s_dm_nxt;
    bad_r <= bad_nxt;
    ma_r <= ma_nxt;    mb_r <= mb_nxt;    acc_r <= acc_nxt; mcnt_r <= mcnt_nxt;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      mbusy_r     <= 1'b0;
      mdone_r     <= 1'b0;
      ovf_r       <= 1'b0;
      have_max_r  <= 1'b0;
      max_num_r   <= 64'd0;
      max_den_r   <= 64'd1;
      sum_num_r   <= 64'd0;
      sum_den_r   <= 64'd1;
      prod_num_r  <= 64'd1;
      prod_den_r  <= 64'd1;
    end else begin
      out_valid_r <= out_valid_nxt;
      mbusy_r     <= mbusy_nxt;
      mdone_r     <= mdone_nxt;
      ovf_r       <= ovf_nxt;
      have_max_r  <= have_max_nxt;
      max_num_r   <= max_num_nxt;
      max_den_r   <= max_den_nxt;
      sum_num_r   <= sum_num_nxt;
      sum_den_r   <= sum_den_nxt;
      prod_num_r  <= prod_num_nxt;
      prod_den_r  <= prod_den_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- hw/rtl/rational_sum_product_max_unit.sv -----
// the time from accepted beat to result depends on the data, through the bit-serial
// divider (64-bit and 128-bit divides, twelve to seventeen of them per beat) and the
// binary gcd unit (one step a cycle, six to eight gcds); a zero denominator goes
// straight from load to output; no new beat is taken until the last one is written out
// to the output register, but a new beat is taken while a result waits there
// reset: synchronous active-low; sum 0/1, product 1/1, maximum 0/1, overflow flag cleared
`default_nettype none
module rational_sum_product_max_unit #(
  parameter int INPUT_WIDTH = 32,
  parameter int ACC_WIDTH   = 64
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire rsp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output rsp_pkg::out_t      out_data
);

  rsp_pkg::cmd_t cmd;
  rsp_pkg::sts_t sts;

  rsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  rsp_dpath #(
    .INPUT_WIDTH (INPUT_WIDTH),
    .ACC_WIDTH   (ACC_WIDTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_stall (out_stall),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ----- hw/rtl/rsp_checker.sv -----
`default_nettype none
module rsp_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire rsp_pkg::out_t out_data
);

  // one beat at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not idle after reset");

  // denominators are always at least one
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.max_den != 63'd0 && out_data.sum_den != 63'd0
                  && out_data.prod_den != 63'd0)
    else $error("zero denominator in result");

endmodule

bind rational_sum_product_max_unit rsp_checker u_rsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ----- tb/sv/rational_sum_product_max_checker.sv -----
`timescale 1ns / 1ps
module rational_sum_product_max_checker (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_stall,
  input  wire rsp_pkg::in_t  in_data,
  input  wire logic          out_valid,
  input  wire logic          out_stall,
  input  wire rsp_pkg::out_t out_data,
  output int                 fail_count,
  output int                 pending
);

  localparam logic [63:0] HALF = 64'h8000_0000_0000_0000;

  logic [63:0]   max_n, max_d, sum_n, sum_d, prod_n, prod_d;
  bit            ovf, seen_max;
  rsp_pkg::out_t totals_q[$];

  assign pending = totals_q.size();

  function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  function automatic logic [63:0] mag_of(input logic [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // wrap to accumulator width when it does not fit, then reduce again
  function automatic void fold_frac(input bit neg, input logic [127:0] nm,
                                    input logic [127:0] dm,
                                    output logic [63:0] num, output logic [63:0] den);
    logic [63:0] v, d, m, g;
    bit fits;
    fits = nm[127:64] == 0 && (nm[63:0] < HALF || (neg && nm[63:0] == HALF)) &&
           dm[127:64] == 0 && dm[63:0] < HALF && dm[63:0] != 0;
    if (!fits) ovf = 1'b1;
    v = neg ? 64'd0 - nm[63:0] : nm[63:0];
    d = {1'b0, dm[62:0]};
    if (d == 0) d = 1;
    m = mag_of(v);
    g = gcd64(m, d);
    m = m / g;
    d = d / g;
    num = v[63] ? 64'd0 - m : m;
    den = d;
  endfunction

  // exact a/b > c/d by cross multiplication
  function automatic bit frac_gt(input bit xn, input logic [63:0] xm, input logic [63:0] xd,
                                 input bit yn, input logic [63:0] ym, input logic [63:0] yd);
    logic [127:0] l, r;
    bit ln, rn;
    l = 128'(xm) * 128'(yd);
    r = 128'(ym) * 128'(xd);
    ln = xn && l != 0;
    rn = yn && r != 0;
    if (ln != rn) return !ln;
    return ln ? l < r : l > r;
  endfunction

  function automatic rsp_pkg::out_t accumulate(input rsp_pkg::in_t b);
    rsp_pkg::out_t o;
    logic [63:0] n, d, nm, dm, g, g1, g2, am, ad, rem;
    logic [127:0] x, y, t, pn, pd;
    bit neg, an, tneg;
    o.bad_item = b.denominator == 0;
    if (!o.bad_item) begin
      n = {{32{b.numerator[31]}}, b.numerator};
      d = {{32{b.denominator[31]}}, b.denominator};
      nm = mag_of(n);
      dm = mag_of(d);
      g = gcd64(nm, dm);
      nm = nm / g;
      dm = dm / g;
      neg = (n[63] != d[63]) && nm != 0;
      if (b.first) begin
        sum_n = 0; sum_d = 1; prod_n = 1; prod_d = 1;
        ovf = 1'b0; seen_max = 1'b0;
      end
      if (!seen_max || frac_gt(neg, nm, dm, max_n[63], mag_of(max_n), max_d))
        fold_frac(neg, 128'(nm), 128'(dm), max_n, max_d);
      seen_max = 1'b1;
      // product with cross cancellation
      an = prod_n[63]; am = mag_of(prod_n); ad = prod_d;
      g1 = gcd64(am, dm);
      g2 = gcd64(nm, ad);
      pn = 128'(am / g1) * 128'(nm / g2);
      pd = 128'(ad / g2) * 128'(dm / g1);
      tneg = an != neg;
      if (pn == 0) begin
        tneg = 1'b0;
        pd = 1;
      end
      fold_frac(tneg, pn, pd, prod_n, prod_d);
      // sum over the common denominator
      an = sum_n[63]; am = mag_of(sum_n); ad = sum_d;
      g = gcd64(ad, dm);
      x = 128'(am) * 128'(dm / g);
      y = 128'(nm) * 128'(ad / g);
      if (an == neg) begin
        tneg = an; t = x + y;
      end else if (x >= y) begin
        tneg = an; t = x - y;
      end else begin
        tneg = neg; t = y - x;
      end
      if (t == 0) fold_frac(1'b0, 128'd0, 128'd1, sum_n, sum_d);
      else begin
        rem = 64'(t % 128'(g));
        g2 = gcd64(rem, g);
        fold_frac(tneg, t / 128'(g2), 128'(ad / g) * 128'(dm / g2), sum_n, sum_d);
      end
    end
    o.max_num = max_n;  o.max_den = max_d[62:0];
    o.sum_num = sum_n;  o.sum_den = sum_d[62:0];
    o.prod_num = prod_n; o.prod_den = prod_d[62:0];
    o.overflow = ovf;
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0h want %0h", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    rsp_pkg::out_t want;
    if (!rst_n) begin
      max_n = 0; max_d = 1; sum_n = 0; sum_d = 1;
      prod_n = 1; prod_d = 1; ovf = 0; seen_max = 0;
      totals_q.delete();
      fail_count = 0;
    end else begin
      // result first: a beat taken at this edge cannot be answered at the same edge
      if (out_valid && !out_stall) begin
        if (totals_q.size() == 0) report_mismatch("unexpected result", 0, 0);
        else begin
          want = totals_q.pop_front();
          if (out_data.max_num !== want.max_num)
            report_mismatch("max_num", out_data.max_num, want.max_num);
          if (out_data.max_den !== want.max_den)
            report_mismatch("max_den", out_data.max_den, want.max_den);
          if (out_data.sum_num !== want.sum_num)
            report_mismatch("sum_num", out_data.sum_num, want.sum_num);
          if (out_data.sum_den !== want.sum_den)
            report_mismatch("sum_den", out_data.sum_den, want.sum_den);
          if (out_data.prod_num !== want.prod_num)
            report_mismatch("prod_num", out_data.prod_num, want.prod_num);
          if (out_data.prod_den !== want.prod_den)
            report_mismatch("prod_den", out_data.prod_den, want.prod_den);
          if (out_data.overflow !== want.overflow)
            report_mismatch("overflow", out_data.overflow, want.overflow);
          if (out_data.bad_item !== want.bad_item)
            report_mismatch("bad_item", out_data.bad_item, want.bad_item);
        end
      end
      if (in_valid && !in_stall) totals_q.push_back(accumulate(in_data));
    end
  end
endmodule

// ----- tb/sv/tb_rational_sum_product_max_unit.sv -----
`timescale 1ns / 1ps
module tb_rational_sum_product_max_unit;

  localparam int CYCLE_LIMIT = 40_000_000;
  localparam int RANDOM_BEATS = 1725;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  rsp_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  rsp_pkg::out_t out_data;
  int            fail_count, pending;
  int            cycles = 0;
  int            send_idle_pct = 0, recv_stall_pct = 0;

  always #2 clk = ~clk;

  rational_sum_product_max_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  rational_sum_product_max_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rational_sum_product_max_unit: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_beat(input logic [31:0] num, input logic [31:0] den, input bit first);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      // mostly short gaps, some long enough to land mid-computation
      gap = ($urandom_range(3) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{numerator: num, denominator: den, first: first};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom_range(0, 20) - 10;
      1: return $urandom_range(0, 2000) - 1000;
      2: return {$urandom_range(1) ? 16'hffff : 16'h0, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] n, d;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero denominator straight after reset, then extremes
    send_beat(32'd5, 32'd0, 1'b1);
    send_beat(32'h8000_0000, 32'd1, 1'b0);
    send_beat(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_beat(32'd0, 32'hffff_ffff, 1'b0);
    send_beat(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_beat(32'd6, -32'sd4, 1'b0);
    send_beat(-32'sd3, 32'd2, 1'b0);
    send_beat(32'd1, 32'd0, 1'b1);
    send_beat(32'd2, 32'd4, 1'b1);
    send_beat(32'd1, 32'd2, 1'b0);
    send_beat(32'd3, 32'd6, 1'b0);
    // product overflow
    send_beat(32'h7fff_ffff, 32'd1, 1'b1);
    send_beat(32'h7fff_ffff, 32'd1, 1'b0);
    send_beat(32'h8000_0000, 32'd1, 1'b0);
    send_beat(32'h7fff_fffd, 32'd3, 1'b0);
    // sum denominators outgrowing the accumulator
    send_beat(32'd1, 32'h7fff_ffff, 1'b1);
    send_beat(32'd1, 32'h7fff_fffe, 1'b0);
    send_beat(-32'sd1, 32'h7fff_fffd, 1'b0);
    send_beat(32'd1, 32'h7fff_ffe7, 1'b0);
    send_beat(32'd1, 32'h7fff_ffc3, 1'b0);
    send_beat(32'd0, 32'd7, 1'b1);
    send_beat(32'hffff_ffff, 32'hffff_ffff, 1'b0);
    send_beat(32'd0, 32'd0, 1'b0);

    for (int i = 0; i < RANDOM_BEATS; i++) begin
      case (i / (RANDOM_BEATS / 5))
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        3: begin send_idle_pct = 33; recv_stall_pct = 33; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      n = rand_word();
      d = rand_word();
      if ($urandom_range(49) == 0) d = 0;
      else if (d == 0) d = 1;
      send_beat(n, d, $urandom_range(7) == 0);
    end
    in_valid <= 1'b0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    if (fail_count == 0) begin
      $display("rational_sum_product_max_unit: match");
    end else begin
      $display("rational_sum_product_max_unit: mismatch");
    end
    $finish;
  end
endmodule
